[src/url_percent_decoder_macros.svh]
// Assertion helpers shared by the decoder modules.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define URLPD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define URLPD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define URLPD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define URLPD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[src/urlpd_pkg.sv]
package urlpd_pkg;

	typedef logic [7:0] octet_t;

	localparam octet_t PCT_CHAR = 8'h25;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT
	} phase_t;

	// Up to three output bytes produced by one input transaction.
	typedef struct packed {
		octet_t [2:0] bytes;
		logic   [1:0] cnt;
		logic         last;
	} job_t;

	function automatic logic is_hex(octet_t c);
		return (c >= 8'h30 && c <= 8'h39) ||
		       (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_nib(octet_t c);
		octet_t d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end else begin
			d = '0;
		end
		return d[3:0];
	endfunction

endpackage

[src/urlpd_front.sv]
`include "url_percent_decoder_macros.svh"

module urlpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              q_wr,
	output urlpd_pkg::job_t   q_job
);

	urlpd_pkg::phase_t phase_q, phase_nxt;
	urlpd_pkg::octet_t held_q;
	logic              held_ld;
	logic              acc;
	logic              fresh_emit;
	urlpd_pkg::phase_t fresh_nxt;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign q_wr     = acc && (q_job.cnt != 2'd0);

	// A fresh '%' opens an escape unless the path ends here.
	assign fresh_emit = (in_byte != urlpd_pkg::PCT_CHAR) || in_last;
	assign fresh_nxt  = fresh_emit ? urlpd_pkg::PH_IDLE : urlpd_pkg::PH_PCT;

	always_comb begin
		q_job      = '0;
		q_job.last = in_last;
		phase_nxt  = fresh_nxt;
		held_ld    = 1'b0;
		case (phase_q)
			urlpd_pkg::PH_PCT: begin
				q_job.bytes[0] = urlpd_pkg::PCT_CHAR;
				q_job.bytes[1] = in_byte;
				if (urlpd_pkg::is_hex(in_byte)) begin
					q_job.cnt = in_last ? 2'd2 : 2'd0;
					phase_nxt = in_last ? urlpd_pkg::PH_IDLE : urlpd_pkg::PH_DIGIT;
					held_ld   = 1'b1;
				end else begin
					q_job.cnt = fresh_emit ? 2'd2 : 2'd1;
				end
			end
			urlpd_pkg::PH_DIGIT: begin
				if (urlpd_pkg::is_hex(in_byte)) begin
					q_job.bytes[0] = {urlpd_pkg::hex_nib(held_q), urlpd_pkg::hex_nib(in_byte)};
					q_job.cnt      = 2'd1;
					phase_nxt      = urlpd_pkg::PH_IDLE;
				end else begin
					q_job.bytes[0] = urlpd_pkg::PCT_CHAR;
					q_job.bytes[1] = held_q;
					q_job.bytes[2] = in_byte;
					q_job.cnt      = fresh_emit ? 2'd3 : 2'd2;
				end
			end
			default: begin
				q_job.bytes[0] = in_byte;
				q_job.cnt      = fresh_emit ? 2'd1 : 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urlpd_pkg::PH_IDLE;
		end else if (acc) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && held_ld) begin
			held_q <= in_byte;
		end
	end

	`URLPD_ASSERT_NXT(a_last_closes_escape, clk, arst_n, acc && in_last, phase_q == urlpd_pkg::PH_IDLE, "escape still open after end of path")
	`URLPD_ASSERT_IMP(a_last_emits, clk, arst_n, acc && in_last, q_wr, "end of path produced no output")

endmodule

[src/urlpd_queue.sv]
`include "url_percent_decoder_macros.svh"

module urlpd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  urlpd_pkg::job_t  wr_job,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output urlpd_pkg::job_t  rd_job
);

	urlpd_pkg::job_t                 mem [urlpd_pkg::QDEPTH];
	logic [urlpd_pkg::QAW-1:0]       wptr_q, rptr_q;
	logic [urlpd_pkg::QCW-1:0]       cnt_q;

	function automatic logic [urlpd_pkg::QAW-1:0] ptr_inc(logic [urlpd_pkg::QAW-1:0] p);
		return (p == urlpd_pkg::QAW'(urlpd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == urlpd_pkg::QCW'(urlpd_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (wr && !pop) begin
				cnt_q <= cnt_q + urlpd_pkg::QCW'(1);
			end else if (pop && !wr) begin
				cnt_q <= cnt_q - urlpd_pkg::QCW'(1);
			end
		end
	end

	`URLPD_ASSERT_IMP(a_no_overflow, clk, arst_n, wr, !full, "queue written while full")
	`URLPD_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, rd_valid, "queue popped while empty")

endmodule

[src/urlpd_back.sv]
`include "url_percent_decoder_macros.svh"

module urlpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  urlpd_pkg::job_t  head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [1:0]        idx_q;
	logic              out_valid_q;
	urlpd_pkg::octet_t out_byte_q;
	logic              out_last_q;
	logic              load;
	logic              final_byte;

	assign load       = head_valid && (!out_valid_q || !out_stall);
	assign final_byte = (idx_q == head.cnt - 2'd1);
	assign pop        = load && final_byte;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			out_last_q <= head.last && final_byte;
		end
	end

	`URLPD_ASSERT_IMP(a_idx_in_job, clk, arst_n, head_valid, (head.cnt != 2'd0) && (idx_q < head.cnt), "byte index outside queued job")

endmodule

[src/url_percent_decoder.sv]
// An accepted input's job is written into the job queue; the serializer then registers its first output byte.
// Throughput: one input per cycle while each byte decodes to at most one output
// and out_stall is low; output runs at one byte per cycle when not stalled, an input
// giving two or three bytes holds the serializer; a 2-entry job queue absorbs bursts.
// Reset (arst_n low, asynchronous): escape state idle, queue empty, no output valid.
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic            q_wr;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	urlpd_pkg::job_t wr_job;
	urlpd_pkg::job_t head_job;

	urlpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_job    (wr_job)
	);

	urlpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_job   (head_job)
	);

	urlpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

[tb/sv/tb_url_percent_decoder.sv]
`timescale 1ns / 100ps

module tb_url_percent_decoder;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_CYCLES   = 200000;
	localparam int SETTLE       = 10;
	localparam int RANDOM_ITEMS = 245;

	typedef struct packed {
		urlpd_pkg::octet_t value;
		logic              last;
	} decoded_t;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	typedef enum {
		TOK_PLAIN,
		TOK_ESCAPE,
		TOK_BAD_FIRST,
		TOK_BAD_SECOND,
		TOK_HALF,
		TOK_NOISE
	} token_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;

	decoded_t          pending_bytes[$];
	urlpd_pkg::phase_t esc_phase;
	urlpd_pkg::octet_t held_digit;
	int                fail_count  = 0;
	int                cycle_count = 0;
	int                burst_left  = 0;

	url_percent_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// value of a hex digit, -1 when the byte is not one
	function automatic int nibble_of(urlpd_pkg::octet_t c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
		return -1;
	endfunction

	// Advance the escape state by one input byte and queue the bytes it yields.
	function void decode_step(urlpd_pkg::octet_t b, logic last);
		urlpd_pkg::octet_t res [3];
		int                n;
		int                lo;
		logic              fresh;
		n = 0;
		fresh = 1'b0;
		case (esc_phase)
			urlpd_pkg::PH_PCT: begin
				if (nibble_of(b) >= 0) begin
					held_digit = b;
					esc_phase = urlpd_pkg::PH_DIGIT;
				end else begin
					res[n] = urlpd_pkg::PCT_CHAR;
					n = n + 1;
					esc_phase = urlpd_pkg::PH_IDLE;
					fresh = 1'b1;
				end
			end
			urlpd_pkg::PH_DIGIT: begin
				lo = nibble_of(b);
				if (lo >= 0) begin
					res[n] = urlpd_pkg::octet_t'((nibble_of(held_digit) << 4) | lo);
					n = n + 1;
				end else begin
					res[n] = urlpd_pkg::PCT_CHAR;
					res[n + 1] = held_digit;
					n = n + 2;
					fresh = 1'b1;
				end
				esc_phase = urlpd_pkg::PH_IDLE;
				held_digit = '0;
			end
			default: begin
				esc_phase = urlpd_pkg::PH_IDLE;
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == urlpd_pkg::PCT_CHAR) begin
				esc_phase = urlpd_pkg::PH_PCT;
			end else begin
				res[n] = b;
				n = n + 1;
			end
		end
		if (last) begin
			// escape cut short by end of path goes out literally
			if (esc_phase == urlpd_pkg::PH_PCT) begin
				res[n] = urlpd_pkg::PCT_CHAR;
				n = n + 1;
			end else if (esc_phase == urlpd_pkg::PH_DIGIT) begin
				res[n] = urlpd_pkg::PCT_CHAR;
				res[n + 1] = held_digit;
				n = n + 2;
			end
			esc_phase = urlpd_pkg::PH_IDLE;
			held_digit = '0;
		end
		for (int i = 0; i < n; i++) begin
			pending_bytes.push_back('{value: res[i], last: last && (i == n - 1)});
		end
	endfunction

	task automatic send_byte(urlpd_pkg::octet_t b, logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                          : $urandom_range(1, 12);
		end
		burst_left = burst_left - 1;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (in_stall);
		decode_step(b, last);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(urlpd_pkg::octet_t'(s[i]), i == s.len() - 1);
		end
	endtask

	// sender holds off until every queued byte has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic urlpd_pkg::octet_t hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10) return urlpd_pkg::octet_t'('h30 + v);
		if (v < 16) return urlpd_pkg::octet_t'('h41 + v - 10);
		return urlpd_pkg::octet_t'('h61 + v - 16);
	endfunction

	function automatic urlpd_pkg::octet_t non_hex_char();
		urlpd_pkg::octet_t c;
		case ($urandom_range(0, 7))
			0: c = 8'h2F;
			1: c = 8'h3A;
			2: c = 8'h40;
			3: c = 8'h47;
			4: c = 8'h60;
			5: c = 8'h67;
			6: c = urlpd_pkg::PCT_CHAR;
			default: begin
				do c = urlpd_pkg::octet_t'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
			end
		endcase
		return c;
	endfunction

	task automatic test_plain_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_valid_escapes();
		send_text("%41");
		send_text("%fF");
		send_text("%9a");
	endtask

	task automatic test_malformed_escapes();
		send_text("%G");
		send_text("%4Z");
		// second digit is itself a percent that then ends the path
		send_text("%4%");
		send_text("%");
		send_text("%a");
	endtask

	task automatic test_random_paths();
		urlpd_pkg::octet_t path[$];
		token_t            tok;
		int                sent;
		logic              paused;
		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			path.delete();
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 9))
					0, 1, 2: tok = TOK_PLAIN;
					3, 4, 5: tok = TOK_ESCAPE;
					6:       tok = TOK_BAD_FIRST;
					7:       tok = TOK_BAD_SECOND;
					8:       tok = TOK_HALF;
					default: tok = TOK_NOISE;
				endcase
				case (tok)
					TOK_PLAIN: begin
						do path.push_back(urlpd_pkg::octet_t'($urandom_range(0, 255)));
						while (path[$] == urlpd_pkg::PCT_CHAR && $urandom_range(0, 3) != 0);
					end
					TOK_ESCAPE: begin
						path.push_back(urlpd_pkg::PCT_CHAR);
						path.push_back(hex_char());
						path.push_back(hex_char());
					end
					TOK_BAD_FIRST: begin
						path.push_back(urlpd_pkg::PCT_CHAR);
						path.push_back(non_hex_char());
					end
					TOK_BAD_SECOND: begin
						path.push_back(urlpd_pkg::PCT_CHAR);
						path.push_back(hex_char());
						path.push_back(non_hex_char());
					end
					TOK_HALF: begin
						path.push_back(urlpd_pkg::PCT_CHAR);
						path.push_back(hex_char());
					end
					default: begin
						path.push_back(($urandom_range(0, 1) == 0) ? urlpd_pkg::PCT_CHAR
						                                          : non_hex_char());
					end
				endcase
			end
			for (int i = 0; i < path.size(); i++) begin
				send_byte(path[i], i == path.size() - 1);
			end
			sent = sent + path.size();
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin : receiver_stall
		stall_mode_t mode;
		out_stall = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HALF:  out_stall <= $urandom_range(0, 1);
					default:     out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_output
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected output transaction: out_byte=%02h out_last=%0b",
				       out_byte, out_last);
				fail_count = fail_count + 1;
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte mismatch: expected %02h, actual %02h",
					       want.value, out_byte);
					fail_count = fail_count + 1;
				end
				if (out_last !== want.last) begin
					$error("out_last mismatch: expected %0b, actual %0b",
					       want.last, out_last);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < MAX_CYCLES) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		in_last = 1'b0;
		esc_phase = urlpd_pkg::PH_IDLE;
		held_digit = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_bytes();
		wait_drained();
		test_valid_escapes();
		wait_drained();
		test_malformed_escapes();
		wait_drained();
		test_random_paths();
		wait_drained();

		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/urlpd_pkg.sv
src/urlpd_front.sv
src/urlpd_queue.sv
src/urlpd_back.sv
src/url_percent_decoder.sv
tb/sv/tb_url_percent_decoder.sv
